@@ design/lmsd_pkg.sv @@
// shared types, constants and arithmetic helpers for the min-sum syndrome decoder
`timescale 1ns / 1ps

package lmsd_pkg;

    localparam int CODE_MAX    = 512;
    localparam int EDGE_MAX    = 2048;
    localparam int MSG_WIDTH   = 8;
    localparam int TOTAL_WIDTH = 12;

    localparam int CODE_AW = $clog2(CODE_MAX);
    localparam int EDGE_AW = $clog2(EDGE_MAX);
    localparam int CS_AW   = $clog2(CODE_MAX + 1);
    localparam int SUM_W   = MSG_WIDTH + EDGE_AW + 1;
    localparam int MAG_W   = MSG_WIDTH - 1;
    localparam int EC_W    = CODE_AW + 1;
    localparam int MP_W    = 2 * MAG_W + 1;

    localparam int MAG_MAX = (1 << (MSG_WIDTH - 1)) - 1;
    localparam int TOT_MAX = (1 << (TOTAL_WIDTH - 1)) - 1;

    // actions
    localparam logic [2:0] ACT_COL_START = 3'd0;
    localparam logic [2:0] ACT_EDGE      = 3'd1;
    localparam logic [2:0] ACT_LLR       = 3'd2;
    localparam logic [2:0] ACT_SYNDROME  = 3'd3;
    localparam logic [2:0] ACT_DECODE    = 3'd4;
    localparam logic [2:0] ACT_READ      = 3'd5;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BIT    = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_VAR_COUNT  = 2'd0;
    localparam logic [1:0] REG_CHK_COUNT  = 2'd1;
    localparam logic [1:0] REG_EDGE_COUNT = 2'd2;
    localparam logic [1:0] REG_ITER_COUNT = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic [11:0]        index;
        logic [11:0]        position;
        logic signed [7:0]  llr;
        logic               syndrome_bit;
    } in_beat_t;

    typedef struct packed {
        logic       kind;
        logic       success;
        logic       decoded_bit;
        logic [8:0] bit_index;
    } out_beat_t;

    // symmetric saturation of a wide sum to a message
    function automatic logic signed [MSG_WIDTH-1:0] sat_msg(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(MAG_MAX)) begin
            return MSG_WIDTH'(MAG_MAX);
        end else if (v < -SUM_W'(MAG_MAX)) begin
            return MSG_WIDTH'(-MAG_MAX);
        end
        return v[MSG_WIDTH-1:0];
    endfunction

    // symmetric saturation of a variable total
    function automatic logic signed [SUM_W-1:0] sat_tot(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(TOT_MAX)) begin
            return SUM_W'(TOT_MAX);
        end else if (v < -SUM_W'(TOT_MAX)) begin
            return SUM_W'(-TOT_MAX);
        end
        return v;
    endfunction

    // floor(sel * 4 / 5) by reciprocal multiply
    function automatic logic [MAG_W-1:0] scale45(input logic [MAG_W-1:0] sel);
        logic [MAG_W+18:0] p;
        p = (MAG_W+19)'({sel, 2'b00}) * (MAG_W+19)'(52429);
        return p[MAG_W+17:18];
    endfunction

endpackage

@@ design/ldpc_min_sum_syndrome_decoder.sv @@
// top level of the normalised min-sum ldpc syndrome decoder
`timescale 1ns / 1ps

// Loads a sparse parity-check graph, intrinsic llrs and syndrome bits through
// the input channel (one load beat per cycle while no result beat is held
// back), then on a decode beat runs iteration_count normalised min-sum
// iterations over the stored graph and returns one status beat saying whether
// every syndrome check is met. A read beat returns the hard decision of one
// variable through the read state and the result register. After reset the
// block clears every entry of the hard decision memory and takes no input
// beat during that time. Every message, pointer and store lives in
// single-port-read memories with a registered read, so a decode is a
// sequencer walking those memories. For each edge, check pass one reads the
// edge, reads the check entry and writes it back, and check pass two writes
// the check-to-variable message in place of the write-back; each edge of a
// variable is visited in a sum pass and an update pass. The result register
// lets a new beat be accepted in the cycle the previous result is taken.

module ldpc_min_sum_syndrome_decoder
    import lmsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_wr_data
);

    // sequencer states
    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_RB   = 5'd2;
    localparam logic [4:0] S_DONE = 5'd3;
    localparam logic [4:0] S_INK  = 5'd4;
    localparam logic [4:0] S_INR  = 5'd5;
    localparam logic [4:0] S_INL  = 5'd6;
    localparam logic [4:0] S_IT   = 5'd7;
    localparam logic [4:0] S_CI   = 5'd8;
    localparam logic [4:0] S_CW   = 5'd9;
    localparam logic [4:0] S_P1A  = 5'd10;
    localparam logic [4:0] S_P1B  = 5'd11;
    localparam logic [4:0] S_P1C  = 5'd12;
    localparam logic [4:0] S_P2A  = 5'd13;
    localparam logic [4:0] S_P2B  = 5'd14;
    localparam logic [4:0] S_P2C  = 5'd15;
    localparam logic [4:0] S_VK   = 5'd16;
    localparam logic [4:0] S_VR   = 5'd17;
    localparam logic [4:0] S_VS1  = 5'd18;
    localparam logic [4:0] S_VS2  = 5'd19;
    localparam logic [4:0] S_VT   = 5'd20;
    localparam logic [4:0] S_VU1  = 5'd21;
    localparam logic [4:0] S_VU2  = 5'd22;
    localparam logic [4:0] S_FC   = 5'd23;
    localparam logic [4:0] S_FCW  = 5'd24;
    localparam logic [4:0] S_FK   = 5'd25;
    localparam logic [4:0] S_FR   = 5'd26;
    localparam logic [4:0] S_FL1  = 5'd27;
    localparam logic [4:0] S_FL2  = 5'd28;
    localparam logic [4:0] S_FL3  = 5'd29;
    localparam logic [4:0] S_FS   = 5'd30;
    localparam logic [4:0] S_FS2  = 5'd31;

    // configuration registers
    logic [9:0]  var_cnt_reg;
    logic [9:0]  chk_cnt_reg;
    logic [11:0] edge_cnt_reg;
    logic [7:0]  iter_cnt_reg;

    // sequencer registers
    logic [4:0]  st_reg, st_next;
    logic [CODE_AW-1:0] clr_reg, clr_next;
    logic [9:0]  k_reg, k_next;
    logic [9:0]  c_reg, c_next;
    logic [11:0] l_reg, l_next;
    logic [11:0] lo_reg, lo_next;
    logic [11:0] hi_reg, hi_next;
    logic [7:0]  it_reg, it_next;
    logic [CODE_AW-1:0] cn_reg, cn_next;
    logic signed [MSG_WIDTH-1:0] v_reg, v_next;
    logic signed [MSG_WIDTH-1:0] llr_reg, llr_next;
    logic signed [SUM_W-1:0] tot_reg, tot_next;
    logic        hd_reg, hd_next;
    logic        ok_reg, ok_next;
    logic [11:0] rb_idx_reg, rb_idx_next;
    logic        m_valid_reg, m_valid_next;
    out_beat_t   m_data_reg, m_data_next;

    // memory ports
    logic                  cs_we;
    logic [CS_AW-1:0]      cs_waddr, cs_raddr_a, cs_raddr_b;
    logic [11:0]           cs_wdata, cs_rd_a, cs_rd_b;
    logic                  ec_we;
    logic [EDGE_AW-1:0]    ec_waddr;
    logic [EC_W-1:0]       ec_wdata, ec_rd;
    logic                  llr_we;
    logic [CODE_AW-1:0]    llr_waddr;
    logic [MSG_WIDTH-1:0]  llr_wdata, llr_rd;
    logic                  syn_we;
    logic [CODE_AW-1:0]    syn_waddr;
    logic                  syn_wdata, syn_rd;
    logic                  v2c_we;
    logic [MSG_WIDTH-1:0]  v2c_wdata, v2c_rd;
    logic                  c2v_we;
    logic [MSG_WIDTH-1:0]  c2v_wdata, c2v_rd;
    logic                  mp_we;
    logic [CODE_AW-1:0]    mp_waddr, mp_raddr;
    logic [MP_W-1:0]       mp_wdata, mp_rd;
    logic                  hd_we;
    logic [CODE_AW-1:0]    hd_waddr, hd_raddr;
    logic                  hd_wdata, hd_rd;

    // working values
    logic [9:0]  n_cnt, m_cnt;
    logic [11:0] e_cnt;
    logic [11:0] rng_hi, rng_lo;
    logic        ec_ok;
    logic        accept;
    logic [MAG_W-1:0] mag, min1, min2, sel, q;
    logic        vneg;
    logic signed [SUM_W-1:0] c2v_ext;

    assign accept  = s_valid && s_ready;
    assign s_ready = (st_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // counts beyond the store depths clamp to the depth
    assign n_cnt = (var_cnt_reg > 10'(CODE_MAX)) ? 10'(CODE_MAX) : var_cnt_reg;
    assign m_cnt = (chk_cnt_reg > 10'(CODE_MAX)) ? 10'(CODE_MAX) : chk_cnt_reg;
    assign e_cnt = (edge_cnt_reg > 12'(EDGE_MAX)) ? 12'(EDGE_MAX) : edge_cnt_reg;

    // edge range of the variable whose column pointers were just read
    assign rng_hi = (cs_rd_b > e_cnt) ? e_cnt : cs_rd_b;
    assign rng_lo = (cs_rd_a > rng_hi) ? rng_hi : cs_rd_a;

    // the top bit marks a check number beyond the store
    assign ec_ok = !ec_rd[EC_W-1] && ({1'b0, ec_rd[CODE_AW-1:0]} < m_cnt);

    // check node arithmetic on the held message and check entry
    assign vneg    = v_reg[MSG_WIDTH-1];
    assign mag     = vneg ? MAG_W'(-v_reg) : v_reg[MAG_W-1:0];
    assign min1    = mp_rd[MP_W-1 -: MAG_W];
    assign min2    = mp_rd[MAG_W:1];
    assign sel     = (mag == min1) ? min2 : min1;
    assign q       = scale45(sel);
    assign c2v_ext = SUM_W'(signed'(c2v_rd));

    // memories
    lmsd_ram #(.DEPTH(CODE_MAX + 1), .WIDTH(12)) u_cs_a (
        .aclk(aclk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .raddr(cs_raddr_a), .rdata(cs_rd_a)
    );
    lmsd_ram #(.DEPTH(CODE_MAX + 1), .WIDTH(12)) u_cs_b (
        .aclk(aclk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .raddr(cs_raddr_b), .rdata(cs_rd_b)
    );
    lmsd_ram #(.DEPTH(EDGE_MAX), .WIDTH(EC_W)) u_ec (
        .aclk(aclk), .we(ec_we), .waddr(ec_waddr), .wdata(ec_wdata),
        .raddr(l_reg[EDGE_AW-1:0]), .rdata(ec_rd)
    );
    lmsd_ram #(.DEPTH(CODE_MAX), .WIDTH(MSG_WIDTH)) u_llr (
        .aclk(aclk), .we(llr_we), .waddr(llr_waddr), .wdata(llr_wdata),
        .raddr(k_reg[CODE_AW-1:0]), .rdata(llr_rd)
    );
    lmsd_ram #(.DEPTH(CODE_MAX), .WIDTH(1)) u_syn (
        .aclk(aclk), .we(syn_we), .waddr(syn_waddr), .wdata(syn_wdata),
        .raddr(c_reg[CODE_AW-1:0]), .rdata(syn_rd)
    );
    lmsd_ram #(.DEPTH(EDGE_MAX), .WIDTH(MSG_WIDTH)) u_v2c (
        .aclk(aclk), .we(v2c_we), .waddr(l_reg[EDGE_AW-1:0]), .wdata(v2c_wdata),
        .raddr(l_reg[EDGE_AW-1:0]), .rdata(v2c_rd)
    );
    lmsd_ram #(.DEPTH(EDGE_MAX), .WIDTH(MSG_WIDTH)) u_c2v (
        .aclk(aclk), .we(c2v_we), .waddr(l_reg[EDGE_AW-1:0]), .wdata(c2v_wdata),
        .raddr(l_reg[EDGE_AW-1:0]), .rdata(c2v_rd)
    );
    lmsd_ram #(.DEPTH(CODE_MAX), .WIDTH(MP_W)) u_mp (
        .aclk(aclk), .we(mp_we), .waddr(mp_waddr), .wdata(mp_wdata),
        .raddr(mp_raddr), .rdata(mp_rd)
    );
    lmsd_ram #(.DEPTH(CODE_MAX), .WIDTH(1)) u_hd (
        .aclk(aclk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(hd_raddr), .rdata(hd_rd)
    );

    // sequencer
    always_comb begin
        st_next      = st_reg;
        clr_next     = clr_reg;
        k_next       = k_reg;
        c_next       = c_reg;
        l_next       = l_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        it_next      = it_reg;
        cn_next      = cn_reg;
        v_next       = v_reg;
        llr_next     = llr_reg;
        tot_next     = tot_reg;
        hd_next      = hd_reg;
        ok_next      = ok_reg;
        rb_idx_next  = rb_idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        cs_we      = 1'b0;
        cs_waddr   = s_data.index[CS_AW-1:0];
        cs_wdata   = s_data.position;
        cs_raddr_a = k_reg;
        cs_raddr_b = k_reg + 10'd1;
        ec_we      = 1'b0;
        ec_waddr   = s_data.index[EDGE_AW-1:0];
        ec_wdata   = {(s_data.position[11:CODE_AW] != '0), s_data.position[CODE_AW-1:0]};
        llr_we     = 1'b0;
        llr_waddr  = s_data.index[CODE_AW-1:0];
        llr_wdata  = s_data.llr;
        syn_we     = 1'b0;
        syn_waddr  = s_data.index[CODE_AW-1:0];
        syn_wdata  = s_data.syndrome_bit;
        v2c_we     = 1'b0;
        v2c_wdata  = sat_msg(SUM_W'(llr_reg));
        c2v_we     = 1'b0;
        c2v_wdata  = '0;
        mp_we      = 1'b0;
        mp_waddr   = cn_reg;
        mp_wdata   = {MAG_W'(MAG_MAX), MAG_W'(MAG_MAX), syn_rd};
        mp_raddr   = c_reg[CODE_AW-1:0];
        hd_we      = 1'b0;
        hd_waddr   = k_reg[CODE_AW-1:0];
        hd_wdata   = 1'b0;
        hd_raddr   = k_reg[CODE_AW-1:0];

        case (st_reg)
            S_CLR: begin
                hd_we    = 1'b1;
                hd_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CODE_AW'(CODE_MAX - 1)) begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE: begin
                hd_raddr = s_data.index[CODE_AW-1:0];
                if (accept) begin
                    case (s_data.action)
                        ACT_COL_START: cs_we  = (s_data.index <= 12'(CODE_MAX));
                        ACT_EDGE:      ec_we  = (s_data.index < 12'(EDGE_MAX));
                        ACT_LLR:       llr_we = (s_data.index < 12'(CODE_MAX));
                        ACT_SYNDROME:  syn_we = (s_data.index < 12'(CODE_MAX));
                        ACT_DECODE: begin
                            k_next  = '0;
                            st_next = S_INK;
                        end
                        ACT_READ: begin
                            rb_idx_next = s_data.index;
                            st_next     = S_RB;
                        end
                        default: ;
                    endcase
                end
            end
            S_RB: begin
                m_valid_next            = 1'b1;
                m_data_next.kind        = KIND_BIT;
                m_data_next.success     = 1'b0;
                m_data_next.decoded_bit = (rb_idx_reg < 12'(CODE_MAX)) ? hd_rd : 1'b0;
                m_data_next.bit_index   = rb_idx_reg[8:0];
                st_next                 = S_IDLE;
            end
            S_DONE: begin
                m_valid_next            = 1'b1;
                m_data_next.kind        = KIND_STATUS;
                m_data_next.success     = ok_reg;
                m_data_next.decoded_bit = 1'b0;
                m_data_next.bit_index   = '0;
                st_next                 = S_IDLE;
            end
            // seed every covered edge with its saturated intrinsic llr
            S_INK: begin
                if (k_reg == n_cnt) begin
                    it_next = '0;
                    st_next = S_IT;
                end else begin
                    st_next = S_INR;
                end
            end
            S_INR: begin
                l_next   = rng_lo;
                hi_next  = rng_hi;
                llr_next = signed'(llr_rd);
                st_next  = S_INL;
            end
            S_INL: begin
                if (l_reg < hi_reg) begin
                    v2c_we = 1'b1;
                    l_next = l_reg + 12'd1;
                end else begin
                    k_next  = k_reg + 10'd1;
                    st_next = S_INK;
                end
            end
            S_IT: begin
                c_next  = '0;
                st_next = (it_reg == iter_cnt_reg) ? S_FC : S_CI;
            end
            // check entries start from the syndrome sign and largest magnitude
            S_CI: begin
                if (c_reg == m_cnt) begin
                    l_next  = '0;
                    st_next = S_P1A;
                end else begin
                    st_next = S_CW;
                end
            end
            S_CW: begin
                mp_we    = 1'b1;
                mp_waddr = c_reg[CODE_AW-1:0];
                c_next   = c_reg + 10'd1;
                st_next  = S_CI;
            end
            // pass one: gather sign parity and two smallest magnitudes
            S_P1A: begin
                if (l_reg == e_cnt) begin
                    l_next  = '0;
                    st_next = S_P2A;
                end else begin
                    st_next = S_P1B;
                end
            end
            S_P1B: begin
                v_next  = signed'(v2c_rd);
                cn_next = ec_rd[CODE_AW-1:0];
                if (ec_ok) begin
                    mp_raddr = ec_rd[CODE_AW-1:0];
                    st_next  = S_P1C;
                end else begin
                    l_next  = l_reg + 12'd1;
                    st_next = S_P1A;
                end
            end
            S_P1C: begin
                mp_we = 1'b1;
                if (min1 > mag) begin
                    mp_wdata = {mag, min1, mp_rd[0] ^ vneg};
                end else if (min2 > mag) begin
                    mp_wdata = {min1, mag, mp_rd[0] ^ vneg};
                end else begin
                    mp_wdata = {min1, min2, mp_rd[0] ^ vneg};
                end
                l_next  = l_reg + 12'd1;
                st_next = S_P1A;
            end
            // pass two: scaled check-to-variable messages
            S_P2A: begin
                if (l_reg == e_cnt) begin
                    k_next  = '0;
                    st_next = S_VK;
                end else begin
                    st_next = S_P2B;
                end
            end
            S_P2B: begin
                v_next  = signed'(v2c_rd);
                cn_next = ec_rd[CODE_AW-1:0];
                if (ec_ok) begin
                    mp_raddr = ec_rd[CODE_AW-1:0];
                    st_next  = S_P2C;
                end else begin
                    c2v_we  = 1'b1;
                    l_next  = l_reg + 12'd1;
                    st_next = S_P2A;
                end
            end
            S_P2C: begin
                c2v_we    = 1'b1;
                c2v_wdata = (mp_rd[0] ^ vneg) ? MSG_WIDTH'(-{1'b0, q}) : MSG_WIDTH'({1'b0, q});
                l_next    = l_reg + 12'd1;
                st_next   = S_P2A;
            end
            // variable pass: total, hard decision, extrinsic messages
            S_VK: begin
                if (k_reg == n_cnt) begin
                    it_next = it_reg + 8'd1;
                    st_next = S_IT;
                end else begin
                    st_next = S_VR;
                end
            end
            S_VR: begin
                lo_next  = rng_lo;
                l_next   = rng_lo;
                hi_next  = rng_hi;
                tot_next = SUM_W'(signed'(llr_rd));
                st_next  = S_VS1;
            end
            S_VS1: begin
                st_next = (l_reg < hi_reg) ? S_VS2 : S_VT;
            end
            S_VS2: begin
                tot_next = tot_reg + c2v_ext;
                l_next   = l_reg + 12'd1;
                st_next  = S_VS1;
            end
            S_VT: begin
                tot_next = sat_tot(tot_reg);
                hd_we    = 1'b1;
                hd_wdata = tot_reg[SUM_W-1];
                l_next   = lo_reg;
                st_next  = S_VU1;
            end
            S_VU1: begin
                if (l_reg < hi_reg) begin
                    st_next = S_VU2;
                end else begin
                    k_next  = k_reg + 10'd1;
                    st_next = S_VK;
                end
            end
            S_VU2: begin
                v2c_we    = 1'b1;
                v2c_wdata = sat_msg(tot_reg - c2v_ext);
                l_next    = l_reg + 12'd1;
                st_next   = S_VU1;
            end
            // syndrome check of the hard decisions
            S_FC: begin
                if (c_reg == m_cnt) begin
                    k_next  = '0;
                    st_next = S_FK;
                end else begin
                    st_next = S_FCW;
                end
            end
            S_FCW: begin
                mp_we    = 1'b1;
                mp_waddr = c_reg[CODE_AW-1:0];
                c_next   = c_reg + 10'd1;
                st_next  = S_FC;
            end
            S_FK: begin
                if (k_reg == n_cnt) begin
                    c_next  = '0;
                    ok_next = 1'b1;
                    st_next = S_FS;
                end else begin
                    st_next = S_FR;
                end
            end
            S_FR: begin
                l_next  = rng_lo;
                hi_next = rng_hi;
                hd_next = hd_rd;
                st_next = S_FL1;
            end
            S_FL1: begin
                if (l_reg < hi_reg) begin
                    st_next = S_FL2;
                end else begin
                    k_next  = k_reg + 10'd1;
                    st_next = S_FK;
                end
            end
            S_FL2: begin
                cn_next = ec_rd[CODE_AW-1:0];
                if (ec_ok) begin
                    mp_raddr = ec_rd[CODE_AW-1:0];
                    st_next  = S_FL3;
                end else begin
                    l_next  = l_reg + 12'd1;
                    st_next = S_FL1;
                end
            end
            S_FL3: begin
                mp_we    = 1'b1;
                mp_wdata = {mp_rd[MP_W-1:1], mp_rd[0] ^ hd_reg};
                l_next   = l_reg + 12'd1;
                st_next  = S_FL1;
            end
            S_FS: begin
                st_next = (c_reg == m_cnt) ? S_DONE : S_FS2;
            end
            S_FS2: begin
                if (mp_rd[0]) begin
                    ok_next = 1'b0;
                end
                c_next  = c_reg + 10'd1;
                st_next = S_FS;
            end
            default: st_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_CLR;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
            var_cnt_reg  <= 10'd396;
            chk_cnt_reg  <= 10'd396;
            edge_cnt_reg <= 12'd1188;
            iter_cnt_reg <= 8'd100;
        end else begin
            st_reg      <= st_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_VAR_COUNT:  var_cnt_reg  <= cfg_wr_data[9:0];
                    REG_CHK_COUNT:  chk_cnt_reg  <= cfg_wr_data[9:0];
                    REG_EDGE_COUNT: edge_cnt_reg <= cfg_wr_data;
                    REG_ITER_COUNT: iter_cnt_reg <= cfg_wr_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        c_reg      <= c_next;
        l_reg      <= l_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        it_reg     <= it_next;
        cn_reg     <= cn_next;
        v_reg      <= v_next;
        llr_reg    <= llr_next;
        tot_reg    <= tot_next;
        hd_reg     <= hd_next;
        ok_reg     <= ok_next;
        rb_idx_reg <= rb_idx_next;
        m_data_reg <= m_data_next;
    end

endmodule

@@ design/lmsd_ram.sv @@
// single write port, single registered read port memory
`timescale 1ns / 1ps

module lmsd_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/lmsd_checker.sv @@
// port-level checks of the decoder, bound to the top level
`timescale 1ns / 1ps

module lmsd_checker
    import lmsd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input in_beat_t    s_data,
    input logic        m_valid,
    input logic        m_ready,
    input out_beat_t   m_data
);

    // a waiting result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // a read beat is answered, through the read state and the result register, with its own variable number
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == ACT_READ |-> ##2
        m_valid && m_data.kind == KIND_BIT &&
        m_data.bit_index == $past(s_data.index[8:0], 2))
        else $error("read beat not answered");

    // load beats give no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid &&
        (s_data.action == ACT_COL_START || s_data.action == ACT_EDGE ||
         s_data.action == ACT_LLR || s_data.action == ACT_SYNDROME) |=> !m_valid)
        else $error("load beat produced a result");

    // unused result fields stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.kind == KIND_STATUS && !m_data.decoded_bit &&
                     m_data.bit_index == '0) ||
                    (m_data.kind == KIND_BIT && !m_data.success))
        else $error("unused result field set");

endmodule

bind ldpc_min_sum_syndrome_decoder lmsd_checker u_lmsd_checker (.*);
